[hw/rtl/jpbb_pkg.sv]
package jpbb_pkg;

   localparam int NJ          = 4;
   localparam int JW          = 2;
   localparam int POS_W       = 12;
   localparam int SPD_W       = 16;
   localparam int SCALE_W     = 7;
   localparam int PROD_W      = POS_W + SCALE_W;
   localparam int QUEUE_DEPTH = 8;
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int ENTRY_W     = POS_W + 1;
   localparam int STORE_DEPTH = NJ * QUEUE_DEPTH;
   localparam int FQ_DEPTH    = 2;
   localparam int OQ_DEPTH    = 4;
   localparam int CSR_IW      = 3;
   localparam int CSR_DW      = 16;

   localparam logic [POS_W:0] WRAP_SPAN = 13'd4095;

   typedef enum logic [1:0] {
      ACT_PUSH        = 2'd0,
      ACT_TICK        = 2'd1,
      ACT_STALL_CHECK = 2'd2,
      ACT_CAPTURE     = 2'd3
   } action_type;

   localparam logic [1:0] DRIVE_STOP = 2'd0;

   localparam logic [CSR_IW-1:0] CSR_DEADBAND    = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_STALL_BAND  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_SLOW_ZONE   = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_SLOW_RATE   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_FAST_RATE   = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_IDLE_RATE   = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_SENSE_MASK  = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_DELTA_SCALE = 3'd7;

   typedef struct packed {
      action_type                  action;
      logic [JW-1:0]               joint;
      logic                        direction;
      logic [POS_W-1:0]            delta_angle;
      logic [NJ-1:0][POS_W-1:0]    pos;
   } item_type;

   typedef struct packed {
      logic [JW-1:0]    joint;
      logic [1:0]       drive;
      logic [SPD_W-1:0] speed;
      logic             arrived;
      logic             stalled;
      logic             accepted;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]   deadband;
      logic [POS_W-1:0]   stall_band;
      logic [POS_W-1:0]   slow_zone;
      logic [SPD_W-1:0]   slow_rate;
      logic [SPD_W-1:0]   fast_rate;
      logic [SPD_W-1:0]   idle_rate;
      logic [NJ-1:0]      sense_mask;
      logic [SCALE_W-1:0] delta_scale;
   } cfg_type;

   function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // 4096 is 1 modulo 4095, so the upper bits fold onto the lower ones.
   function automatic logic [POS_W-1:0] mod_span(input logic [PROD_W-1:0] p);
      logic [POS_W:0] s;
      s = (POS_W+1)'(p[PROD_W-1:POS_W]) + {1'b0, p[POS_W-1:0]};
      return (s >= WRAP_SPAN) ? POS_W'(s - WRAP_SPAN) : s[POS_W-1:0];
   endfunction

endpackage

[hw/rtl/jpbb_ram.sv]
module jpbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[hw/rtl/jpbb_front.sv]
module jpbb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jpbb_pkg::item_type item_in,
   output logic              full,
   output logic              valid,
   output jpbb_pkg::item_type item_out,
   input  logic              take
);
   import jpbb_pkg::*;

   localparam int AW = $clog2(FQ_DEPTH);

   item_type          mem_ff [FQ_DEPTH];
   logic [AW-1:0]     wp_ff, rp_ff;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              wr, rd;

   assign full  = (cnt_ff == (AW+1)'(FQ_DEPTH));
   assign valid = (cnt_ff != '0);
   assign wr    = push && !full;
   assign rd    = take && valid;
   assign item_out = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (wr && !rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd && !wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (wr) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (rd) begin
            rp_ff <= rp_ff + 1'b1;
         end
      end
      if (wr) begin
         mem_ff[wp_ff] <= item_in;
      end
   end
endmodule

[hw/rtl/jpbb_rsp_fifo.sv]
module jpbb_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  jpbb_pkg::rsp_type rsp_in,
   output logic             full,
   output logic             empty,
   output jpbb_pkg::rsp_type rsp_out,
   input  logic             pop
);
   import jpbb_pkg::*;

   localparam int AW = $clog2(OQ_DEPTH);

   rsp_type       mem_ff [OQ_DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          rd;

   assign full    = (cnt_ff == (AW+1)'(OQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd      = pop && !empty;
   assign rsp_out = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (wr && !rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd && !wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (wr) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (rd) begin
            rp_ff <= rp_ff + 1'b1;
         end
      end
      if (wr) begin
         mem_ff[wp_ff] <= rsp_in;
      end
   end
endmodule

[hw/rtl/jpbb_back.sv]
module jpbb_back (
   input  logic               clock,
   input  logic               reset,
   input  jpbb_pkg::cfg_type  cfg,
   input  logic               in_valid,
   input  jpbb_pkg::item_type in_item,
   output logic               in_take,
   input  logic               out_full,
   output logic               out_wr,
   output jpbb_pkg::rsp_type  out_rsp
);
   import jpbb_pkg::*;

   // Steps of a four-joint item: 0..3 read the store, 1..4 scale, 2..5 update.
   localparam logic [2:0] STEP_LAST = 3'd5;

   logic                  busy_ff;
   item_type              cur_ff;
   logic [2:0]            k_ff;
   logic [SLOT_W-1:0]     head_ff   [NJ];
   logic [CNT_W-1:0]      cnt_ff    [NJ];
   logic [POS_W-1:0]      target_ff [NJ];
   logic [POS_W-1:0]      stop_ff   [NJ];
   logic [POS_W-1:0]      prev_ff   [NJ];
   logic [NJ-1:0]         dir_ff, arr_ff, stp_ff, stl_ff;
   logic [POS_W-1:0]      d_ff;
   logic                  mdir_ff;

   logic                  is_push, adv, done, upd;
   logic [JW-1:0]         rj, pj, cj;
   logic [2:0]            km2;
   logic                  re, we, room;
   logic [ENTRY_W-1:0]    rdata;
   logic [SLOT_W-1:0]     slot;
   logic [PROD_W-1:0]     prod;

   logic [POS_W-1:0]      p, stop_c, newt, tgt, ad_t, ad_s;
   logic [POS_W:0]        sum_up;
   logic                  up, pop;

   logic [POS_W-1:0]      target_in, stop_in, prev_in;
   logic                  dir_in, arr_in, stp_in, stl_in;
   logic [1:0]            drv;
   logic [SPD_W-1:0]      spd;

   assign is_push = (cur_ff.action == ACT_PUSH);
   assign adv     = busy_ff && ((!is_push && k_ff < 3'd2) || !out_full);
   assign done    = adv && (is_push || k_ff == STEP_LAST);
   assign in_take = in_valid && (!busy_ff || done);
   assign upd     = adv && !is_push && k_ff >= 3'd2;

   assign rj   = k_ff[JW-1:0];
   assign km2  = k_ff - 3'd2;
   assign cj   = km2[JW-1:0];
   assign pj   = cur_ff.joint;
   assign re   = adv && !is_push && k_ff < 3'd4;
   assign room = (cnt_ff[pj] < CNT_W'(QUEUE_DEPTH));
   assign we   = adv && is_push && room;
   assign slot = head_ff[pj] + cnt_ff[pj][SLOT_W-1:0];

   jpbb_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (we),
      .waddr ({pj, slot}),
      .wdata ({cur_ff.direction, cur_ff.delta_angle}),
      .re    (re),
      .raddr ({rj, head_ff[rj]}),
      .rdata (rdata)
   );

   assign prod = PROD_W'(rdata[POS_W-1:0]) * PROD_W'(cfg.delta_scale);

   // Target of a popped command: stop position moved by the scaled angle.
   assign p      = cur_ff.pos[cj];
   assign stop_c = stop_ff[cj];
   assign up     = cfg.sense_mask[cj] ^ mdir_ff;
   assign sum_up = {1'b0, stop_c} + {1'b0, d_ff};
   always_comb begin
      if (up) begin
         newt = (sum_up > WRAP_SPAN) ? POS_W'(sum_up - WRAP_SPAN) : sum_up[POS_W-1:0];
      end else begin
         newt = (stop_c >= d_ff) ? stop_c - d_ff
                                 : POS_W'({1'b0, stop_c} + WRAP_SPAN - {1'b0, d_ff});
      end
   end

   assign pop  = stp_ff[cj] && (cnt_ff[cj] != '0) && !stl_ff[cj];
   assign tgt  = pop ? newt : target_ff[cj];
   assign ad_t = abs_diff(p, tgt);
   assign ad_s = abs_diff(p, prev_ff[cj]);

   always_comb begin
      target_in = target_ff[cj];
      stop_in   = stop_c;
      prev_in   = prev_ff[cj];
      dir_in    = dir_ff[cj];
      arr_in    = arr_ff[cj];
      stp_in    = stp_ff[cj];
      stl_in    = stl_ff[cj];
      drv       = DRIVE_STOP;
      spd       = cfg.idle_rate;
      case (cur_ff.action)
         ACT_TICK: begin
            if (!stl_ff[cj]) begin
               if (pop) begin
                  target_in = newt;
                  dir_in    = mdir_ff;
                  arr_in    = 1'b0;
               end
               if (!arr_in) begin
                  if (ad_t < cfg.deadband) begin
                     arr_in  = 1'b1;
                     stp_in  = 1'b1;
                     stop_in = p;
                  end else begin
                     stp_in = 1'b0;
                     drv    = {dir_in, ~dir_in};
                     spd    = (ad_t < cfg.slow_zone) ? cfg.slow_rate : cfg.fast_rate;
                  end
               end
            end
         end
         ACT_STALL_CHECK: begin
            if (!stp_ff[cj]) begin
               if (ad_s < cfg.stall_band) begin
                  stl_in = 1'b1;
                  stp_in = 1'b1;
               end else begin
                  stl_in = 1'b0;
               end
               prev_in = p;
            end
            drv = stp_in ? DRIVE_STOP : {dir_in, ~dir_in};
            spd = stp_in ? cfg.idle_rate : '0;
         end
         ACT_CAPTURE: begin
            stop_in   = p;
            target_in = p;
            prev_in   = p;
            arr_in    = 1'b1;
            stp_in    = 1'b1;
            stl_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_rsp = '0;
      if (is_push) begin
         out_rsp.joint    = pj;
         out_rsp.drive    = stp_ff[pj] ? DRIVE_STOP : {dir_ff[pj], ~dir_ff[pj]};
         out_rsp.speed    = stp_ff[pj] ? cfg.idle_rate : '0;
         out_rsp.arrived  = arr_ff[pj];
         out_rsp.stalled  = stl_ff[pj];
         out_rsp.accepted = room;
         out_rsp.last     = 1'b1;
      end else begin
         out_rsp.joint    = cj;
         out_rsp.drive    = drv;
         out_rsp.speed    = spd;
         out_rsp.arrived  = arr_in;
         out_rsp.stalled  = stl_in;
         out_rsp.accepted = 1'b0;
         out_rsp.last     = (k_ff == STEP_LAST);
      end
   end

   assign out_wr = adv && (is_push || k_ff >= 3'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
         dir_ff  <= '0;
         arr_ff  <= '1;
         stp_ff  <= '1;
         stl_ff  <= '0;
         for (int j = 0; j < NJ; j++) begin
            head_ff[j]   <= '0;
            cnt_ff[j]    <= '0;
            target_ff[j] <= '0;
            stop_ff[j]   <= '0;
            prev_ff[j]   <= '0;
         end
      end else begin
         if (in_take) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
         end else if (done) begin
            busy_ff <= 1'b0;
         end else if (adv) begin
            k_ff <= k_ff + 3'd1;
         end
         if (we) begin
            cnt_ff[pj] <= cnt_ff[pj] + CNT_W'(1);
         end
         if (upd) begin
            target_ff[cj] <= target_in;
            stop_ff[cj]   <= stop_in;
            prev_ff[cj]   <= prev_in;
            dir_ff[cj]    <= dir_in;
            arr_ff[cj]    <= arr_in;
            stp_ff[cj]    <= stp_in;
            stl_ff[cj]    <= stl_in;
            if (cur_ff.action == ACT_TICK && pop) begin
               head_ff[cj] <= head_ff[cj] + 1'b1;
               cnt_ff[cj]  <= cnt_ff[cj] - CNT_W'(1);
            end
         end
      end
      if (in_take) begin
         cur_ff <= in_item;
      end
      if (adv && k_ff >= 3'd1 && k_ff <= 3'd4) begin
         d_ff    <= mod_span(prod);
         mdir_ff <= rdata[ENTRY_W-1];
      end
   end
endmodule

[hw/rtl/joint_position_bang_bang_controller_top.sv]
// Channel   Ports                                      Transfer when
// input     req_push, req_full, req_<field>            req_push && !req_full
// result    rsp_empty, rsp_pop, rsp_<field>            rsp_pop && !rsp_empty
// config    csr_we, csr_index, csr_wdata               csr_we
//
// The executor handles a push directly; a tick, stall check or capture first reads the
// command store and scales, then updates one joint per cycle while the result queue is not full.
// A two-entry input queue and a four-entry result queue decouple both sides.
// Synchronous reset leaves all joints arrived and stopped with empty command queues.
// The executor stalls only when the result queue is full.
module joint_position_bang_bang_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_joint,
   input  logic        req_direction,
   input  logic [11:0] req_delta_angle,
   input  logic [11:0] req_pos_head,
   input  logic [11:0] req_pos_waist,
   input  logic [11:0] req_pos_left_arm,
   input  logic [11:0] req_pos_right_arm,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_out_joint,
   output logic [1:0]  rsp_drive,
   output logic [15:0] rsp_speed,
   output logic        rsp_arrived,
   output logic        rsp_stalled,
   output logic        rsp_accepted,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [jpbb_pkg::CSR_IW-1:0] csr_index,
   input  logic [jpbb_pkg::CSR_DW-1:0] csr_wdata
);
   import jpbb_pkg::*;

   cfg_type  cfg_ff;
   item_type req_item, front_item;
   rsp_type  back_rsp, head_rsp;
   logic     front_valid, take, out_full, out_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband    <= 12'd20;
         cfg_ff.stall_band  <= 12'd5;
         cfg_ff.slow_zone   <= 12'd100;
         cfg_ff.slow_rate   <= 16'd300;
         cfg_ff.fast_rate   <= 16'd800;
         cfg_ff.idle_rate   <= 16'd0;
         cfg_ff.sense_mask  <= 4'hf;
         cfg_ff.delta_scale <= 7'd11;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEADBAND:    cfg_ff.deadband    <= csr_wdata[POS_W-1:0];
            CSR_STALL_BAND:  cfg_ff.stall_band  <= csr_wdata[POS_W-1:0];
            CSR_SLOW_ZONE:   cfg_ff.slow_zone   <= csr_wdata[POS_W-1:0];
            CSR_SLOW_RATE:   cfg_ff.slow_rate   <= csr_wdata;
            CSR_FAST_RATE:   cfg_ff.fast_rate   <= csr_wdata;
            CSR_IDLE_RATE:   cfg_ff.idle_rate   <= csr_wdata;
            CSR_SENSE_MASK:  cfg_ff.sense_mask  <= csr_wdata[NJ-1:0];
            CSR_DELTA_SCALE: cfg_ff.delta_scale <= csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_item.action      = action_type'(req_action);
      req_item.joint       = req_joint;
      req_item.direction   = req_direction;
      req_item.delta_angle = req_delta_angle;
      req_item.pos[0]      = req_pos_head;
      req_item.pos[1]      = req_pos_waist;
      req_item.pos[2]      = req_pos_left_arm;
      req_item.pos[3]      = req_pos_right_arm;
   end

   jpbb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .item_in  (req_item),
      .full     (req_full),
      .valid    (front_valid),
      .item_out (front_item),
      .take     (take)
   );

   jpbb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (front_valid),
      .in_item  (front_item),
      .in_take  (take),
      .out_full (out_full),
      .out_wr   (out_wr),
      .out_rsp  (back_rsp)
   );

   jpbb_rsp_fifo u_rsp (
      .clock   (clock),
      .reset   (reset),
      .wr      (out_wr),
      .rsp_in  (back_rsp),
      .full    (out_full),
      .empty   (rsp_empty),
      .rsp_out (head_rsp),
      .pop     (rsp_pop)
   );

   assign rsp_out_joint = head_rsp.joint;
   assign rsp_drive     = head_rsp.drive;
   assign rsp_speed     = head_rsp.speed;
   assign rsp_arrived   = head_rsp.arrived;
   assign rsp_stalled   = head_rsp.stalled;
   assign rsp_accepted  = head_rsp.accepted;
   assign rsp_last      = head_rsp.last;

   // A latched stall always comes with the joint stopped.
   a_stall_stops: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_stalled) |-> (rsp_drive == DRIVE_STOP))
      else $error("stalled joint reported as driving");

   // Only a push answer can carry the accepted flag, and it is always final.
   a_accept_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_accepted) |-> rsp_last)
      else $error("accepted result not marked last");

   // The executor never writes into a full result queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_wr |-> !out_full)
      else $error("result queue overflow");
endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import jpbb_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      action_type        action;
      logic [1:0]        joint;
      logic              direction;
      logic [11:0]       delta_angle;
      logic [3:0][11:0]  pos;
   } command_item;

   typedef struct packed {
      logic [1:0]  joint;
      logic [1:0]  drive;
      logic [15:0] speed;
      logic        arrived;
      logic        stalled;
      logic        accepted;
      logic        last;
   } joint_report;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_action;
   logic [1:0]  req_joint;
   logic        req_direction;
   logic [11:0] req_delta_angle;
   logic [11:0] req_pos_head;
   logic [11:0] req_pos_waist;
   logic [11:0] req_pos_left_arm;
   logic [11:0] req_pos_right_arm;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_out_joint;
   logic [1:0]  rsp_drive;
   logic [15:0] rsp_speed;
   logic        rsp_arrived;
   logic        rsp_stalled;
   logic        rsp_accepted;
   logic        rsp_last;
   logic        csr_we;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   joint_position_bang_bang_controller_top dut (.*);

   // Predictor state: configuration and per-joint controller state.
   logic [11:0] m_deadband, m_stall_band, m_slow_zone;
   logic [15:0] m_slow_rate, m_fast_rate, m_idle_rate;
   logic [3:0]  m_sense_mask;
   logic [6:0]  m_delta_scale;
   logic [12:0] m_store [4][QUEUE_DEPTH];
   int          m_head [4];
   int          m_count [4];
   logic [11:0] m_target [4];
   logic [11:0] m_stop [4];
   logic [11:0] m_prev [4];
   logic        m_dir [4];
   logic        m_arrived [4];
   logic        m_stopped [4];
   logic        m_stall [4];

   command_item pending_items[$];
   joint_report expected_reports[$];

   int  errors = 0;
   int  transfers_in = 0;
   int  transfers_out = 0;
   int  idle_cycles = 0;
   bit  hold_off_request = 0;
   bit  holding_off = 0;
   int  hold_off_left = 0;
   int  send_gap = 0;
   int  pop_gap = 0;
   int  ticks_sent = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic logic [11:0] distance(input logic [11:0] a, input logic [11:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic joint_report report_of(input int j, input logic [1:0] drive,
                                             input logic [15:0] speed, input logic acc,
                                             input logic last);
      joint_report r;
      r.joint = j[1:0];
      r.drive = drive;
      r.speed = speed;
      r.arrived = m_arrived[j];
      r.stalled = m_stall[j];
      r.accepted = acc;
      r.last = last;
      return r;
   endfunction

   function automatic logic [1:0] held_drive(input int j);
      return m_stopped[j] ? DRIVE_STOP : 2'd1 + m_dir[j];
   endfunction

   function automatic logic [15:0] held_speed(input int j);
      return m_stopped[j] ? m_idle_rate : 16'd0;
   endfunction

   task automatic reset_controller_model();
      m_deadband = 12'd20; m_stall_band = 12'd5; m_slow_zone = 12'd100;
      m_slow_rate = 16'd300; m_fast_rate = 16'd800; m_idle_rate = 16'd0;
      m_sense_mask = 4'hF; m_delta_scale = 7'd11;
      for (int j = 0; j < 4; j++) begin
         m_head[j] = 0; m_count[j] = 0;
         m_target[j] = '0; m_stop[j] = '0; m_prev[j] = '0; m_dir[j] = 1'b0;
         m_arrived[j] = 1'b1; m_stopped[j] = 1'b1; m_stall[j] = 1'b0;
      end
   endtask

   task automatic take_next_command(input int j);
      logic [12:0] e;
      logic [18:0] scaled;
      int          d, s, t;
      bit          up;
      e = m_store[j][m_head[j]];
      scaled = 19'(e[11:0]) * 19'(m_delta_scale);
      d = int'(scaled % 19'd4095);
      up = (m_sense_mask[j] == 1'b1) == (e[12] == 1'b0);
      s = int'(m_stop[j]);
      m_head[j] = (m_head[j] + 1) % QUEUE_DEPTH;
      m_count[j]--;
      if (up) begin
         t = s + d;
         if (t > 4095) t -= 4095;
      end else begin
         t = (s >= d) ? s - d : s + 4095 - d;
      end
      m_target[j] = t[11:0];
      m_dir[j] = e[12];
      m_arrived[j] = 1'b0;
   endtask

   task automatic predict_controller(input command_item it);
      logic [11:0] ad;
      logic [1:0]  drive;
      logic [15:0] speed;
      bit          acc;
      int          jn;
      if (it.action == ACT_PUSH) begin
         jn = int'(it.joint);
         acc = 1'b0;
         if (m_count[jn] < QUEUE_DEPTH) begin
            m_store[jn][(m_head[jn] + m_count[jn]) % QUEUE_DEPTH] =
               {it.direction, it.delta_angle};
            m_count[jn]++;
            acc = 1'b1;
         end
         expected_reports.push_back(report_of(jn, held_drive(jn), held_speed(jn), acc,
                                              1'b1));
         return;
      end
      for (int j = 0; j < 4; j++) begin
         drive = DRIVE_STOP;
         speed = m_idle_rate;
         case (it.action)
            ACT_TICK: begin
               if (!m_stall[j]) begin
                  if (m_stopped[j] && m_count[j] > 0) take_next_command(j);
                  if (!m_arrived[j]) begin
                     ad = distance(it.pos[j], m_target[j]);
                     if (ad < m_deadband) begin
                        m_arrived[j] = 1'b1; m_stopped[j] = 1'b1;
                        m_stop[j] = it.pos[j];
                     end else begin
                        m_stopped[j] = 1'b0;
                        drive = 2'd1 + m_dir[j];
                        speed = (ad < m_slow_zone) ? m_slow_rate : m_fast_rate;
                     end
                  end
               end
            end
            ACT_STALL_CHECK: begin
               if (!m_stopped[j]) begin
                  if (distance(it.pos[j], m_prev[j]) < m_stall_band) begin
                     m_stall[j] = 1'b1; m_stopped[j] = 1'b1;
                  end else begin
                     m_stall[j] = 1'b0;
                  end
                  m_prev[j] = it.pos[j];
               end
               drive = held_drive(j);
               speed = held_speed(j);
            end
            default: begin
               m_stop[j] = it.pos[j]; m_target[j] = it.pos[j]; m_prev[j] = it.pos[j];
               m_arrived[j] = 1'b1; m_stopped[j] = 1'b1; m_stall[j] = 1'b0;
            end
         endcase
         expected_reports.push_back(report_of(j, drive, speed, 1'b0, j == 3));
      end
   endtask

   // Driver: one transfer per accepted item, with a random gap between items.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap <= 0;
         req_action <= ACT_PUSH;
         req_joint <= '0;
         req_direction <= 1'b0;
         req_delta_angle <= '0;
         req_pos_head <= '0;
         req_pos_waist <= '0;
         req_pos_left_arm <= '0;
         req_pos_right_arm <= '0;
      end else if (req_push && req_full) begin
         // Offer stays up until the block takes it.
      end else begin
         if (req_push) begin
            predict_controller(pending_items.pop_front());
            transfers_in++;
         end
         if (pending_items.size() == 0) begin
            req_push <= 1'b0;
         end else if (send_gap > 0) begin
            req_push <= 1'b0;
            send_gap <= send_gap - 1;
         end else begin
            req_push <= 1'b1;
            req_action <= pending_items[0].action;
            req_joint <= pending_items[0].joint;
            req_direction <= pending_items[0].direction;
            req_delta_angle <= pending_items[0].delta_angle;
            req_pos_head <= pending_items[0].pos[0];
            req_pos_waist <= pending_items[0].pos[1];
            req_pos_left_arm <= pending_items[0].pos[2];
            req_pos_right_arm <= pending_items[0].pos[3];
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 6));
         end
      end
   end

   // Monitor: compares each result transfer with the oldest expectation.
   always @(posedge clock) begin
      joint_report got, want;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            transfers_out++;
            got = '{rsp_out_joint, rsp_drive, rsp_speed, rsp_arrived, rsp_stalled,
                    rsp_accepted, rsp_last};
            if (expected_reports.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result: joint %0d", got.joint);
            end else begin
               want = expected_reports.pop_front();
               if (got != want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch: expected j%0d drv%0d spd%0d arr%0d stl%0d acc%0d lst%0d",
                              want.joint, want.drive, want.speed, want.arrived,
                              want.stalled, want.accepted, want.last);
                     $display("          got      j%0d drv%0d spd%0d arr%0d stl%0d acc%0d lst%0d",
                              got.joint, got.drive, got.speed, got.arrived,
                              got.stalled, got.accepted, got.last);
                  end
               end
            end
         end
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;

         if (hold_off_request && !holding_off) begin
            holding_off <= 1'b1;
            hold_off_left <= 300;
            rsp_pop <= 1'b0;
         end else if (holding_off) begin
            if (hold_off_left == 0) begin
               holding_off <= 1'b0;
               rsp_pop <= 1'b1;
            end else begin
               hold_off_left <= hold_off_left - 1;
               rsp_pop <= 1'b0;
            end
         end else if (rsp_pop && !rsp_empty) begin
            pop_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 6));
            rsp_pop <= 1'b0;
         end else if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic command_item push_item(input int j, input bit dir, input int angle);
      command_item it;
      it.action = ACT_PUSH;
      it.joint = j[1:0];
      it.direction = dir;
      it.delta_angle = angle[11:0];
      for (int k = 0; k < 4; k++) it.pos[k] = 12'($urandom_range(0, 4095));
      return it;
   endfunction

   function automatic command_item sample_item(input action_type act, input int p0,
                                                input int p1, input int p2, input int p3);
      command_item it;
      it.action = act;
      it.joint = 2'($urandom_range(0, 3));
      it.direction = 1'($urandom_range(0, 1));
      it.delta_angle = 12'($urandom_range(0, 4095));
      it.pos = {p3[11:0], p2[11:0], p1[11:0], p0[11:0]};
      return it;
   endfunction

   task automatic write_register(input logic [CSR_IW-1:0] idx, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEADBAND:    m_deadband = value[11:0];
         CSR_STALL_BAND:  m_stall_band = value[11:0];
         CSR_SLOW_ZONE:   m_slow_zone = value[11:0];
         CSR_SLOW_RATE:   m_slow_rate = value[15:0];
         CSR_FAST_RATE:   m_fast_rate = value[15:0];
         CSR_IDLE_RATE:   m_idle_rate = value[15:0];
         CSR_SENSE_MASK:  m_sense_mask = value[3:0];
         CSR_DELTA_SCALE: m_delta_scale = value[6:0];
         default: begin
         end
      endcase
   endtask

   task automatic drain_results();
      int guard;
      guard = 0;
      while ((pending_items.size() != 0 || req_push || expected_reports.size() != 0)
             && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      // The executor may still be busy briefly after the last result.
      repeat (12) @(posedge clock);
   endtask

   // A motion episode: capture, a few commands, then sampled actions (mostly ticks and stall
   // checks, sometimes a push) whose samples jump, hold or creep upward so joints may arrive or stall.
   task automatic queue_motion_episode(input int moves);
      int p [4];
      int act;
      for (int k = 0; k < 4; k++) p[k] = $urandom_range(0, 4095);
      pending_items.push_back(sample_item(ACT_CAPTURE, p[0], p[1], p[2], p[3]));
      for (int m = 0; m < moves; m++)
         pending_items.push_back(push_item($urandom_range(0, 3), 1'($urandom_range(0, 1)),
                                           ($urandom_range(0, 7) == 0) ?
                                           $urandom_range(0, 4095) : $urandom_range(0, 40)));
      for (int s = 0; s < 6; s++) begin
         act = $urandom_range(0, 9);
         for (int k = 0; k < 4; k++)
            case ($urandom_range(0, 3))
               0: p[k] = $urandom_range(0, 4095);
               1: p[k] = p[k];
               default: p[k] = (p[k] + $urandom_range(0, 200)) % 4096;
            endcase
         pending_items.push_back(sample_item(act < 6 ? ACT_TICK :
                                             act < 9 ? ACT_STALL_CHECK : ACT_PUSH,
                                             p[0], p[1], p[2], p[3]));
         ticks_sent++;
      end
   endtask

   initial begin
      csr_we = 1'b0; csr_index = CSR_DEADBAND; csr_wdata = '0;
      reset = 1'b1;
      reset_controller_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every action, full queue, wrap both ways,
      // stalled joint, capture clearing a stall.
      pending_items.push_back(sample_item(ACT_TICK, 0, 4095, 0, 4095));
      pending_items.push_back(sample_item(ACT_CAPTURE, 0, 4095, 2000, 10));
      pending_items.push_back(push_item(0, 1'b0, 4095));
      pending_items.push_back(push_item(1, 1'b1, 4095));
      pending_items.push_back(push_item(2, 1'b0, 0));
      for (int k = 0; k < 9; k++) pending_items.push_back(push_item(3, k[0], 100 * k));
      pending_items.push_back(sample_item(ACT_TICK, 0, 4095, 2000, 10));
      pending_items.push_back(sample_item(ACT_STALL_CHECK, 1, 4094, 2000, 12));
      pending_items.push_back(sample_item(ACT_TICK, 1, 4094, 2000, 12));
      pending_items.push_back(sample_item(ACT_STALL_CHECK, 4095, 0, 4095, 4095));
      pending_items.push_back(sample_item(ACT_TICK, 4095, 0, 4095, 4095));
      pending_items.push_back(sample_item(ACT_CAPTURE, 4095, 4095, 4095, 4095));
      pending_items.push_back(sample_item(ACT_TICK, 4095, 4095, 4095, 4095));
      drain_results();

      // Extreme register settings, including zero deadband and zero scale.
      write_register(CSR_DEADBAND, 0);
      write_register(CSR_STALL_BAND, 4095);
      write_register(CSR_SLOW_ZONE, 0);
      write_register(CSR_SLOW_RATE, 16'hFFFF);
      write_register(CSR_FAST_RATE, 0);
      write_register(CSR_IDLE_RATE, 16'hFFFF);
      write_register(CSR_SENSE_MASK, 0);
      write_register(CSR_DELTA_SCALE, 0);
      queue_motion_episode(5);
      queue_motion_episode(3);
      drain_results();

      write_register(CSR_DEADBAND, 4095);
      write_register(CSR_STALL_BAND, 0);
      write_register(CSR_SLOW_ZONE, 4095);
      write_register(CSR_DELTA_SCALE, 127);
      write_register(CSR_SENSE_MASK, 4'b1010);
      queue_motion_episode(6);
      drain_results();

      // Random phases; the receiver holds off during one so the block backs up.
      for (int phase = 0; phase < 4; phase++) begin
         write_register(CSR_DEADBAND, $urandom_range(0, 60));
         write_register(CSR_STALL_BAND, $urandom_range(0, 30));
         write_register(CSR_SLOW_ZONE, $urandom_range(0, 400));
         write_register(CSR_SLOW_RATE, $urandom_range(0, 65535));
         write_register(CSR_FAST_RATE, $urandom_range(0, 65535));
         write_register(CSR_IDLE_RATE, $urandom_range(0, 65535));
         write_register(CSR_SENSE_MASK, $urandom_range(0, 15));
         write_register(CSR_DELTA_SCALE, $urandom_range(1, 64));
         if (phase == 1) hold_off_request = 1'b1;
         for (int e = 0; e < 4; e++) queue_motion_episode($urandom_range(1, 6));
         if (phase == 1) begin
            wait (holding_off);
            hold_off_request = 1'b0;
         end
         drain_results();
      end

      $display("covered %0d input transfers and %0d result transfers,", transfers_in,
               transfers_out);
      $display("with %0d sampled actions across extreme and random settings", ticks_sent);
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
